// ----- sv/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer.
// No dependencies; used by byte_ring_buffer and brb_ram.
`timescale 1ns / 1ps

package brb_pkg;

	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int FIELD_W = 10;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_ADV_WR  = 3'd3,
		OP_ADV_RD  = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

endpackage

// ----- sv/brb_ram.sv -----
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on brb_pkg for the byte width.
`timescale 1ns / 1ps

module brb_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [brb_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [brb_pkg::BYTE_W-1:0] rdata
);

	logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [brb_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/byte_ring_buffer.sv -----
// Byte ring buffer: CAPACITY bytes in CAPACITY+1 slots, one slot kept empty.
// Each transaction passes through capture, memory access and pointer update,
// and status computation; a new one is accepted only once the last is through,
// and a stalled output holds the last step.
// Reset clears both pointers and the fill count; the byte store is not cleared.
// Depends on brb_pkg and brb_ram.
`timescale 1ns / 1ps

module byte_ring_buffer #(
	parameter int CAPACITY = 1023
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [brb_pkg::OP_W-1:0]    operation,
	input  logic [brb_pkg::BYTE_W-1:0]  data_in,
	input  logic [brb_pkg::FIELD_W-1:0] count,
	input  logic [brb_pkg::FIELD_W-1:0] peek_offset,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [brb_pkg::BYTE_W-1:0]  data_out,
	output logic [brb_pkg::FIELD_W-1:0] moved,
	output logic [brb_pkg::FIELD_W-1:0] used_bytes,
	output logic [brb_pkg::FIELD_W-1:0] free_bytes,
	output logic [brb_pkg::FIELD_W-1:0] contig_write_span,
	output logic [brb_pkg::FIELD_W-1:0] contig_read_span,
	output logic [brb_pkg::FIELD_W-1:0] read_slot,
	output logic [brb_pkg::FIELD_W-1:0] write_slot
);

	localparam int SLOTS = CAPACITY + 1;
	localparam int PW    = $clog2(SLOTS);
	// arithmetic width: holds SLOTS itself and any 10-bit field
	localparam int W     = (PW + 1 > brb_pkg::FIELD_W + 1) ? PW + 1 : brb_pkg::FIELD_W + 1;
	localparam logic [W-1:0] SLOTS_W = W'(SLOTS);
	localparam logic [W-1:0] CAP_W   = W'(CAPACITY);
	localparam logic [W-1:0] ONE_W   = W'(1);
	localparam logic [W-1:0] ZERO_W  = '0;

	function automatic logic [W-1:0] wrap_w(input logic [W-1:0] s);
		return (s >= SLOTS_W) ? s - SLOTS_W : s;
	endfunction

	brb_pkg::state_t state_q, state_nx;
	logic load_out;

	// captured transaction
	logic [brb_pkg::OP_W-1:0]    op_s1;
	logic [brb_pkg::BYTE_W-1:0]  din_s1;
	logic [brb_pkg::FIELD_W-1:0] cnt_s1;
	logic [brb_pkg::FIELD_W-1:0] off_s1;

	logic [PW-1:0] rp_q, wp_q, used_q;
	logic [brb_pkg::FIELD_W-1:0] moved_s2;
	logic                        dout_en_s2;

	logic out_valid_q;
	logic [brb_pkg::BYTE_W-1:0]  data_out_q;
	logic [brb_pkg::FIELD_W-1:0] moved_q, used_out_q, free_out_q;
	logic [brb_pkg::FIELD_W-1:0] wspan_q, rspan_q, rslot_q, wslot_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------- FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		case (state_q)
			brb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_nx = brb_pkg::ST_EXEC;
			end
			brb_pkg::ST_EXEC: begin
				state_nx = brb_pkg::ST_FIN;
			end
			brb_pkg::ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_nx = brb_pkg::ST_IDLE;
				end
			end
			default: state_nx = brb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			din_s1 <= data_in;
			cnt_s1 <= count;
			off_s1 <= peek_offset;
		end
	end

	// ------------------------------------------------- execute: memory access
	logic [W-1:0] rp_w, wp_w, used_w, free_w, cnt_w, off_w;
	logic [W-1:0] rp_nx, wp_nx, moved_w, addr_w;
	logic         ram_we, ram_re;

	assign rp_w   = {{(W-PW){1'b0}}, rp_q};
	assign wp_w   = {{(W-PW){1'b0}}, wp_q};
	assign used_w = {{(W-PW){1'b0}}, used_q};
	assign free_w = CAP_W - used_w;
	assign cnt_w  = {{(W-brb_pkg::FIELD_W){1'b0}}, cnt_s1};
	assign off_w  = {{(W-brb_pkg::FIELD_W){1'b0}}, off_s1};

	always_comb begin
		rp_nx   = rp_w;
		wp_nx   = wp_w;
		moved_w = ZERO_W;
		addr_w  = ZERO_W;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		case (op_s1)
			brb_pkg::OP_PUSH: begin
				if (free_w != ZERO_W) begin
					wp_nx   = wrap_w(wp_w + ONE_W);
					addr_w  = wp_nx;
					ram_we  = 1'b1;
					moved_w = ONE_W;
				end
			end
			brb_pkg::OP_POP: begin
				if (used_w != ZERO_W) begin
					rp_nx   = wrap_w(rp_w + ONE_W);
					addr_w  = rp_nx;
					ram_re  = 1'b1;
					moved_w = ONE_W;
				end
			end
			brb_pkg::OP_PEEK: begin
				// offset below used keeps the sum under twice the slot count
				if (off_w < used_w) begin
					addr_w  = wrap_w(rp_w + ONE_W + off_w);
					ram_re  = 1'b1;
					moved_w = ONE_W;
				end
			end
			brb_pkg::OP_ADV_WR: begin
				moved_w = (cnt_w < free_w) ? cnt_w : free_w;
				wp_nx   = wrap_w(wp_w + moved_w);
			end
			brb_pkg::OP_ADV_RD: begin
				moved_w = (cnt_w < used_w) ? cnt_w : used_w;
				rp_nx   = wrap_w(rp_w + moved_w);
			end
			brb_pkg::OP_CLEAR: begin
				rp_nx = ZERO_W;
				wp_nx = ZERO_W;
			end
			default: ;
		endcase
	end

	logic exec;
	assign exec = (state_q == brb_pkg::ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else if (exec) begin
			rp_q <= rp_nx[PW-1:0];
			wp_q <= wp_nx[PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			moved_s2   <= moved_w[brb_pkg::FIELD_W-1:0];
			dout_en_s2 <= ram_re;
		end
	end

	logic [brb_pkg::BYTE_W-1:0] ram_rdata;

	brb_ram #(
		.DEPTH (SLOTS),
		.AW    (PW)
	) u_ram (
		.clk   (clk),
		.we    (exec && ram_we),
		.waddr (addr_w[PW-1:0]),
		.wdata (din_s1),
		.re    (exec && ram_re),
		.raddr (addr_w[PW-1:0]),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------ finish: status fields
	logic [W-1:0] used_f, free_f, nw_f, nr_f, wspan_f, rspan_f;

	always_comb begin
		used_f  = (wp_w >= rp_w) ? wp_w - rp_w : wp_w + SLOTS_W - rp_w;
		free_f  = CAP_W - used_f;
		nw_f    = wrap_w(wp_w + ONE_W);
		nr_f    = wrap_w(rp_w + ONE_W);
		wspan_f = (rp_w < nw_f) ? SLOTS_W - nw_f : rp_w - nw_f;
		if (rp_w == wp_w) begin
			rspan_f = ZERO_W;
		end else if (nr_f > wp_w) begin
			rspan_f = SLOTS_W - nr_f;
		end else begin
			rspan_f = wp_w - nr_f + ONE_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				used_q      <= used_f[PW-1:0];
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			data_out_q <= dout_en_s2 ? ram_rdata : '0;
			moved_q    <= moved_s2;
			used_out_q <= used_f[brb_pkg::FIELD_W-1:0];
			free_out_q <= free_f[brb_pkg::FIELD_W-1:0];
			wspan_q    <= wspan_f[brb_pkg::FIELD_W-1:0];
			rspan_q    <= rspan_f[brb_pkg::FIELD_W-1:0];
			rslot_q    <= nr_f[brb_pkg::FIELD_W-1:0];
			wslot_q    <= nw_f[brb_pkg::FIELD_W-1:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign data_out          = data_out_q;
	assign moved             = moved_q;
	assign used_bytes        = used_out_q;
	assign free_bytes        = free_out_q;
	assign contig_write_span = wspan_q;
	assign contig_read_span  = rspan_q;
	assign read_slot         = rslot_q;
	assign write_slot        = wslot_q;

	// ------------------------------------------------------------ checks
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_w < SLOTS_W) && (wp_w < SLOTS_W) && (used_w <= CAP_W))
		else $error("pointer or fill count out of range");

	a_ptr_moves_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(rp_q) || !$stable(wp_q)) |-> $past(state_q) == brb_pkg::ST_EXEC)
		else $error("pointer changed outside execute step");

	a_used_tracks_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brb_pkg::ST_IDLE) |-> used_w == used_f)
		else $error("fill count disagrees with pointers");

endmodule

// ----- tb/sv/byte_ring_buffer_tb.sv -----
// Self-checking testbench for byte_ring_buffer: directed corner cases, then
// random push/pop/peek/advance traffic with random idling on both channels.
// Depends on brb_pkg and the byte_ring_buffer RTL.
`timescale 1ns / 1ps

module byte_ring_buffer_tb;
	import brb_pkg::*;

	localparam int CAPACITY = 1023;
	localparam int SLOTS    = CAPACITY + 1;
	localparam int AW       = $clog2(SLOTS);
	localparam int LIMIT    = 400000;

	// codes 6 and 7 are unused by the block; they must act as no-ops
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_SKIP} traffic_t;

	typedef struct {
		logic [BYTE_W-1:0]  data_out;
		logic [FIELD_W-1:0] moved;
		logic [FIELD_W-1:0] used_bytes;
		logic [FIELD_W-1:0] free_bytes;
		logic [FIELD_W-1:0] contig_write_span;
		logic [FIELD_W-1:0] contig_read_span;
		logic [FIELD_W-1:0] read_slot;
		logic [FIELD_W-1:0] write_slot;
	} ring_status_t;

	class ring_scoreboard;
		logic [BYTE_W-1:0] bytes [SLOTS];
		bit                filled [SLOTS];
		int                rd_ptr;
		int                wr_ptr;
		ring_status_t      status_q [$];
		int                errors;

		function logic [AW-1:0] slot_of(int s);
			return AW'(s % SLOTS);
		endfunction

		function int held();
			return (wr_ptr + SLOTS - rd_ptr) % SLOTS;
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		// true unless the op would read a slot that was never written
		function bit read_ok(logic [OP_W-1:0] op, logic [FIELD_W-1:0] off);
			if (op == OP_POP && held() > 0)
				return filled[slot_of(rd_ptr + 1)];
			if (op == OP_PEEK && int'(off) < held())
				return filled[slot_of(rd_ptr + 1 + int'(off))];
			return 1'b1;
		endfunction

		function void note(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
				logic [FIELD_W-1:0] cnt, logic [FIELD_W-1:0] off);
			int used;
			int spare;
			int n;
			int nw;
			int nr;
			int rspan;
			ring_status_t e;
			used = held();
			spare = CAPACITY - used;
			e.data_out = '0;
			e.moved = '0;
			case (op)
				OP_PUSH: if (spare > 0) begin
					wr_ptr = (wr_ptr + 1) % SLOTS;
					bytes[slot_of(wr_ptr)] = din;
					filled[slot_of(wr_ptr)] = 1'b1;
					e.moved = 1;
				end
				OP_POP: if (used > 0) begin
					rd_ptr = (rd_ptr + 1) % SLOTS;
					e.data_out = bytes[slot_of(rd_ptr)];
					e.moved = 1;
				end
				OP_PEEK: if (int'(off) < used) begin
					e.data_out = bytes[slot_of(rd_ptr + 1 + int'(off))];
					e.moved = 1;
				end
				OP_ADV_WR: begin
					n = (int'(cnt) < spare) ? int'(cnt) : spare;
					wr_ptr = (wr_ptr + n) % SLOTS;
					e.moved = FIELD_W'(n);
				end
				OP_ADV_RD: begin
					n = (int'(cnt) < used) ? int'(cnt) : used;
					rd_ptr = (rd_ptr + n) % SLOTS;
					e.moved = FIELD_W'(n);
				end
				OP_CLEAR: begin
					rd_ptr = 0;
					wr_ptr = 0;
				end
				default: ;
			endcase
			used = held();
			e.used_bytes = FIELD_W'(used);
			e.free_bytes = FIELD_W'(CAPACITY - used);
			nw = (wr_ptr + 1) % SLOTS;
			e.contig_write_span = FIELD_W'((rd_ptr < nw) ? SLOTS - nw : rd_ptr - nw);
			nr = (rd_ptr + 1) % SLOTS;
			if (rd_ptr == wr_ptr)
				rspan = 0;
			else
				rspan = (nr > wr_ptr) ? SLOTS - nr : wr_ptr - nr + 1;
			e.contig_read_span = FIELD_W'(rspan);
			e.read_slot = FIELD_W'(nr);
			e.write_slot = FIELD_W'(nw);
			status_q.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %0s", $time, msg);
			errors++;
		endtask

		task cmp_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%0s got %0d expected %0d", name, got, want));
		endtask

		task check(ring_status_t got);
			ring_status_t e;
			if (status_q.size() == 0) begin
				report("result transaction with nothing expected");
				return;
			end
			e = status_q.pop_front();
			cmp_field("data_out", int'(got.data_out), int'(e.data_out));
			cmp_field("moved", int'(got.moved), int'(e.moved));
			cmp_field("used_bytes", int'(got.used_bytes), int'(e.used_bytes));
			cmp_field("free_bytes", int'(got.free_bytes), int'(e.free_bytes));
			cmp_field("contig_write_span", int'(got.contig_write_span),
				int'(e.contig_write_span));
			cmp_field("contig_read_span", int'(got.contig_read_span),
				int'(e.contig_read_span));
			cmp_field("read_slot", int'(got.read_slot), int'(e.read_slot));
			cmp_field("write_slot", int'(got.write_slot), int'(e.write_slot));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    operation = OP_PUSH;
	logic [BYTE_W-1:0]  data_in = '0;
	logic [FIELD_W-1:0] count = '0;
	logic [FIELD_W-1:0] peek_offset = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [BYTE_W-1:0]  data_out;
	logic [FIELD_W-1:0] moved;
	logic [FIELD_W-1:0] used_bytes;
	logic [FIELD_W-1:0] free_bytes;
	logic [FIELD_W-1:0] contig_write_span;
	logic [FIELD_W-1:0] contig_read_span;
	logic [FIELD_W-1:0] read_slot;
	logic [FIELD_W-1:0] write_slot;

	bit             quiet;
	int             cycles;
	ring_scoreboard sb;

	byte_ring_buffer #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.data_in(data_in),
		.count(count),
		.peek_offset(peek_offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.moved(moved),
		.used_bytes(used_bytes),
		.free_bytes(free_bytes),
		.contig_write_span(contig_write_span),
		.contig_read_span(contig_read_span),
		.read_slot(read_slot),
		.write_slot(write_slot)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("byte_ring_buffer_tb: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 14);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{data_out, moved, used_bytes, free_bytes, contig_write_span,
				contig_read_span, read_slot, write_slot});
	end

	// Sends one transaction; reads of never-written slots are steered away.
	task automatic issue(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
			logic [FIELD_W-1:0] cnt, logic [FIELD_W-1:0] off);
		if (!sb.read_ok(op, off)) begin
			if (op == OP_POP) begin
				op = OP_ADV_RD;
				cnt = 1;
			end else if (sb.held() < CAPACITY) begin
				off = FIELD_W'($urandom_range(1022, sb.held()));
			end else begin
				op = OP_ADV_RD;
				cnt = 0;
			end
		end
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_in <= din;
		count <= cnt;
		peek_offset <= off;
		do @(posedge clk); while (in_stall);
		sb.note(op, din, cnt, off);
	endtask

	function automatic logic [OP_W-1:0] pick_op(traffic_t mix);
		int push_pct;
		int pop_pct;
		int r;
		int r2;
		case (mix)
			MIX_FILL:     begin push_pct = 70; pop_pct = 15; end
			MIX_DRAIN:    begin push_pct = 15; pop_pct = 70; end
			MIX_BALANCED: begin push_pct = 45; pop_pct = 40; end
			default:      begin push_pct = 20; pop_pct = 20; end
		endcase
		r = $urandom_range(99);
		r2 = $urandom_range(99);
		if (r < push_pct) return OP_PUSH;
		if (r < push_pct + pop_pct) return OP_POP;
		if (r2 < 40) return OP_PEEK;
		if (r2 < 70) return OP_ADV_WR;
		if (r2 < 95) return OP_ADV_RD;
		if (r2 < 98) return OP_CLEAR;
		return $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
	endfunction

	function automatic logic [FIELD_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70) return FIELD_W'($urandom_range(8));
		if (r < 90) return FIELD_W'($urandom_range(1023));
		return 10'd1023;
	endfunction

	function automatic logic [FIELD_W-1:0] pick_offset();
		if ($urandom_range(99) < 70 && sb.held() > 0)
			return FIELD_W'($urandom_range(sb.held() - 1));
		return FIELD_W'($urandom_range(1022));
	endfunction

	initial begin
		traffic_t mix;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// empty buffer corners
		issue(OP_POP, 8'h00, 0, 0);
		issue(OP_PEEK, 8'h00, 0, 0);
		issue(OP_ADV_RD, 8'h00, 5, 0);
		issue(OP_PUSH, 8'h00, 0, 0);
		issue(OP_PUSH, 8'hFF, 0, 0);
		issue(OP_PUSH, 8'hA5, 0, 0);
		issue(OP_PEEK, 8'h00, 0, 0);
		issue(OP_PEEK, 8'h00, 0, 2);
		issue(OP_PEEK, 8'h00, 0, 3);
		issue(OP_PEEK, 8'h00, 0, 1022);
		issue(OP_POP, 8'h00, 0, 0);
		issue(OP_ADV_WR, 8'h00, 0, 0);
		issue(OP_ADV_RD, 8'h00, 0, 0);
		// clamp to free space -> full, then push into a full buffer
		issue(OP_ADV_WR, 8'h00, 1023, 0);
		issue(OP_PUSH, 8'h5A, 0, 0);
		issue(OP_PEEK, 8'h00, 0, 1022);
		issue(OP_RSVD6, 8'h00, 0, 0);
		issue(OP_RSVD7, 8'h00, 0, 0);
		issue(OP_ADV_RD, 8'h00, 1023, 0);
		issue(OP_CLEAR, 8'h00, 0, 0);
		issue(OP_PUSH, 8'h3C, 0, 0);
		issue(OP_POP, 8'h00, 0, 0);
		issue(OP_ADV_WR, 8'h00, 512, 0);
		issue(OP_ADV_RD, 8'h00, 512, 0);

		for (int chunk = 0; chunk < 9; chunk++) begin
			mix = (chunk == 0) ? MIX_FILL : traffic_t'($urandom_range(3));
			quiet = (chunk == 2);
			if (chunk == 5) begin
				// drop valid first so the last transaction is not taken twice
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			for (int i = 0; i < 100; i++)
				issue(pick_op(mix), BYTE_W'($urandom_range(255)), pick_count(),
					pick_offset());
		end
		quiet = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("byte_ring_buffer_tb: PASS");
		else
			$display("byte_ring_buffer_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
sv/brb_pkg.sv
sv/brb_ram.sv
sv/byte_ring_buffer.sv
tb/sv/byte_ring_buffer_tb.sv
